// File: design/iptl_pkg.sv
// Shared types, codes and helpers for the IPv4 prefix table.
package iptl_pkg;

    localparam int IPTL_ENTRIES_DEF = 64;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_CHECK  = 2'd2;

    localparam logic [5:0] LEN_MAX = 6'd32;
    localparam logic signed [6:0] MATCH_NONE = -7'sd1;

    typedef enum logic [2:0] {
        ST_DONE       = 3'd0,
        ST_PRESENT    = 3'd1,
        ST_ABSENT     = 3'd2,
        ST_BAD_LENGTH = 3'd3,
        ST_FULL       = 3'd4
    } t_status;

    typedef struct packed {
        logic        valid;
        logic [31:0] prefix;
        logic [5:0]  len;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic scan_rd;
        logic commit;
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last_addr;
        logic need_scan;
    } t_dp_stat;

    // Mask keeping the top len bits; all ones for len >= 32.
    function automatic logic [31:0] length_mask(input logic [5:0] len);
        length_mask = ~(32'hFFFF_FFFF >> len);
    endfunction

endpackage

// File: design/iptl_ctrl.sv
// Sequencer for the prefix table: clear pass, table scan, commit, result strobe.
module iptl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output logic              o_valid,
    output iptl_pkg::t_ctrl_cmd o_cmd,
    input  iptl_pkg::t_dp_stat  i_stat
);
    import iptl_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.last_addr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.load = start;
                if (start) begin
                    n_state = i_stat.need_scan ? S_SCAN : S_COMMIT;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_stat.last_addr) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_COMMIT);
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;

    a_strobe_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state) == S_COMMIT)
        else $error("result strobe without commit");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make the block busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe longer than one cycle");

endmodule

// File: design/iptl_dp.sv
// Datapath: entry memory, scan counter, match accumulators and result registers.
module iptl_dp #(
    parameter int TABLE_ENTRIES = iptl_pkg::IPTL_ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  iptl_pkg::t_ctrl_cmd i_cmd,
    output iptl_pkg::t_dp_stat  o_stat,
    input  logic [1:0]          i_command,
    input  logic [31:0]         i_address,
    input  logic [5:0]          i_prefix_length,
    output logic [2:0]          o_status,
    output logic signed [6:0]   o_match_length
);
    import iptl_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    t_entry r_mem [TABLE_ENTRIES];

    logic [IW-1:0] r_cnt;
    t_entry        r_rd_data;
    logic          r_rd_vld;

    // latched command word
    logic [1:0]    r_cmd;
    logic [31:0]   r_addr;
    logic [31:0]   r_base;
    logic [5:0]    r_len;
    logic          r_bad;

    // scan accumulators
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic          r_free;
    logic [IW-1:0] r_free_idx;
    logic          r_best_vld;
    logic [5:0]    r_best_len;
    logic [IW-1:0] r_rd_idx;

    logic [2:0]        r_status;
    logic signed [6:0] r_match;

    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    t_entry            wr_data;
    logic [2:0]        res_status;
    logic signed [6:0] res_match;
    logic              e_same;
    logic              e_cover;
    logic [31:0]       e_mask;
    logic              in_bad;

    assign in_bad = (i_prefix_length > LEN_MAX);
    assign o_stat.last_addr = (r_cnt == LAST_IDX);
    assign o_stat.need_scan = (i_command == CMD_CHECK) ||
                              (((i_command == CMD_ADD) || (i_command == CMD_DELETE)) && !in_bad);

    // per-entry compare on the registered read word
    assign e_mask  = length_mask(r_rd_data.len);
    assign e_same  = r_rd_data.valid && (r_rd_data.prefix == r_base) && (r_rd_data.len == r_len);
    assign e_cover = r_rd_data.valid &&
                     ((r_addr & e_mask) == (r_rd_data.prefix & e_mask));

    // commit decision and table update
    always_comb begin
        wr_en      = 1'b0;
        wr_addr    = r_cnt;
        wr_data    = '0;
        res_status = ST_DONE;
        res_match  = MATCH_NONE;
        if (i_cmd.clear) begin
            wr_en = 1'b1;
        end else if (i_cmd.commit) begin
            case (r_cmd)
                CMD_ADD: begin
                    if (r_bad) begin
                        res_status = ST_BAD_LENGTH;
                    end else if (r_hit) begin
                        res_status = ST_PRESENT;
                    end else if (!r_free) begin
                        res_status = ST_FULL;
                    end else begin
                        wr_en          = 1'b1;
                        wr_addr        = r_free_idx;
                        wr_data.valid  = 1'b1;
                        wr_data.prefix = r_base;
                        wr_data.len    = r_len;
                    end
                end
                CMD_DELETE: begin
                    if (r_bad) begin
                        res_status = ST_BAD_LENGTH;
                    end else if (r_hit) begin
                        wr_en   = 1'b1;
                        wr_addr = r_hit_idx;
                    end else begin
                        res_status = ST_ABSENT;
                    end
                end
                CMD_CHECK: begin
                    if (r_best_vld) begin
                        res_match = signed'({1'b0, r_best_len});
                    end
                end
                default: begin
                    res_status = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.scan_rd) begin
            r_rd_data <= r_mem[r_cnt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_rd_vld   <= 1'b0;
            r_hit      <= 1'b0;
            r_free     <= 1'b0;
            r_best_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.load) begin
                r_cnt      <= '0;
                r_hit      <= 1'b0;
                r_free     <= 1'b0;
                r_best_vld <= 1'b0;
            end else begin
                if (i_cmd.clear || i_cmd.scan_rd) begin
                    r_cnt <= (r_cnt == LAST_IDX) ? '0 : r_cnt + 1'b1;
                end
                if (r_rd_vld) begin
                    if (!r_hit && e_same) begin
                        r_hit <= 1'b1;
                    end
                    if (!r_free && !r_rd_data.valid) begin
                        r_free <= 1'b1;
                    end
                    if (e_cover && (!r_best_vld || (r_rd_data.len > r_best_len))) begin
                        r_best_vld <= 1'b1;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_cnt;
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_addr <= i_address;
            r_base <= i_address & length_mask(i_prefix_length);
            r_len  <= i_prefix_length;
            r_bad  <= in_bad;
        end
        if (r_rd_vld && !i_cmd.load) begin
            if (!r_hit && e_same) begin
                r_hit_idx <= r_rd_idx;
            end
            if (!r_free && !r_rd_data.valid) begin
                r_free_idx <= r_rd_idx;
            end
            if (e_cover && (!r_best_vld || (r_rd_data.len > r_best_len))) begin
                r_best_len <= r_rd_data.len;
            end
        end
        if (i_cmd.commit) begin
            r_status <= res_status;
            r_match  <= res_match;
        end
    end

    assign o_status       = r_status;
    assign o_match_length = r_match;

    a_drained_at_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !r_rd_vld)
        else $error("commit while a table read is still in flight");

    a_best_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_vld |-> (r_best_len <= LEN_MAX))
        else $error("best match length above 32");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !i_cmd.scan_rd && !r_rd_vld)
        else $error("table write during scan");

endmodule

// File: design/ipv4_prefix_table_lpm_unit.sv
// Top level of the IPv4 longest-prefix-match table: controller plus datapath.
// Add, delete and check scan the whole table before the result strobe; a bad length
// on add or delete, or the unused command, skips the scan and goes straight to commit.
// A new word is taken only when busy is low again, once the previous word has reached
// commit; the scan reads the single-port entry memory one entry per cycle.
// Reset: a clearing pass over every entry follows reset, busy stays high.
// The result strobe o_valid lasts one cycle; the receiver cannot stall it.
module ipv4_prefix_table_lpm_unit #(
    parameter int TABLE_ENTRIES = iptl_pkg::IPTL_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_command,
    input  logic [31:0]       i_address,
    input  logic [5:0]        i_prefix_length,
    output logic              o_valid,
    output logic [2:0]        o_status,
    output logic signed [6:0] o_match_length
);
    import iptl_pkg::*;

    // Command and status bundles between the sequencer and the datapath.
    t_ctrl_cmd ctrl_cmd;
    t_dp_stat  dp_stat;

    // Sequencer: clear pass after reset, then a scan per accepted check, add or delete with a legal length.
    iptl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (ctrl_cmd),
        .i_stat  (dp_stat)
    );

    // Datapath: entry memory with valid field, compare logic, accumulators and
    // the registered result fields that line up with o_valid.
    iptl_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctrl_cmd),
        .o_stat          (dp_stat),
        .i_command       (i_command),
        .i_address       (i_address),
        .i_prefix_length (i_prefix_length),
        .o_status        (o_status),
        .o_match_length  (o_match_length)
    );

endmodule

// File: tb/sv/ipv4_prefix_table_lpm_unit_test.sv
// Self-checking testbench for the IPv4 longest-prefix-match table unit.
module ipv4_prefix_table_lpm_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import iptl_pkg::*;

    localparam int TABLE_ENTRIES = IPTL_ENTRIES_DEF;
    localparam int CLK_PERIOD    = 20;
    localparam int WORD_TARGET   = 700;
    // Slowest legal run is ~725 words, each a busy window plus the longest gap,
    // plus drain pauses; the limit leaves several times that.
    localparam int CYCLE_LIMIT   = 800_000;
    localparam int ROW_COUNT     = 25;
    localparam int PRINT_CAP     = 50;

    // Command code 3 has no meaning; the unit must ignore it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One result word as the unit reports it.
    typedef struct packed {
        t_status           status;
        logic signed [6:0] match_len;
    } t_lpm_result;

    // One stimulus word; fixed_exp marks rows whose result is typed in.
    typedef struct packed {
        logic [1:0]        cmd;
        logic [31:0]       addr;
        logic [5:0]        plen;
        bit                fixed_exp;
        t_status           status;
        logic signed [6:0] match_len;
    } t_stim_row;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              start           = 1'b0;
    logic              busy;
    logic [1:0]        i_command       = '0;
    logic [31:0]       i_address       = '0;
    logic [5:0]        i_prefix_length = '0;
    logic              o_valid;
    logic [2:0]        o_status;
    logic signed [6:0] o_match_length;

    // Shadow copy of the prefix table, updated at each accepting edge.
    bit          lpm_valid [TABLE_ENTRIES];
    logic [31:0] lpm_base  [TABLE_ENTRIES];
    logic [5:0]  lpm_len   [TABLE_ENTRIES];

    t_lpm_result pending_results[$];
    t_stim_row   directed_rows [ROW_COUNT];

    int n_errors   = 0;
    int n_sent     = 0;
    int n_cycles   = 0;
    int burst_left = 0;

    ipv4_prefix_table_lpm_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_address      (i_address),
        .i_prefix_length(i_prefix_length),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_match_length (o_match_length)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Hard stop if the unit hangs or results never arrive.
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Keeps the top plen bits; plen is 0..32 wherever this is called.
    function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
        return (plen == 6'd0) ? 32'h0 : (32'hFFFF_FFFF << (6'd32 - plen));
    endfunction

    function automatic int lpm_count();
        int n;
        n = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (lpm_valid[i]) n++;
        return n;
    endfunction

    // Applies one word to the shadow table and returns the result it gives.
    function automatic t_lpm_result lpm_apply(input logic [1:0] cmd,
                                              input logic [31:0] addr,
                                              input logic [5:0] plen);
        t_lpm_result r;
        logic [31:0] base;
        logic [31:0] m;
        int          hit;
        int          slot;
        int          best;
        r.status    = ST_DONE;
        r.match_len = MATCH_NONE;
        case (cmd)
            CMD_ADD, CMD_DELETE: begin
                if (plen > LEN_MAX) begin
                    r.status = ST_BAD_LENGTH;
                end else begin
                    base = addr & prefix_mask(plen);
                    hit  = -1;
                    slot = -1;
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (hit < 0 && lpm_valid[i] && lpm_base[i] == base &&
                            lpm_len[i] == plen)
                            hit = i;
                        if (slot < 0 && !lpm_valid[i])
                            slot = i;
                    end
                    if (cmd == CMD_ADD) begin
                        // duplicate wins over full
                        if (hit >= 0) begin
                            r.status = ST_PRESENT;
                        end else if (slot < 0) begin
                            r.status = ST_FULL;
                        end else begin
                            lpm_valid[slot] = 1'b1;
                            lpm_base[slot]  = base;
                            lpm_len[slot]   = plen;
                        end
                    end else if (hit >= 0) begin
                        lpm_valid[hit] = 1'b0;
                    end else begin
                        r.status = ST_ABSENT;
                    end
                end
            end
            CMD_CHECK: begin
                // length field is ignored on a check
                best = -1;
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    m = prefix_mask(lpm_len[i]);
                    if (lpm_valid[i] && (addr & m) == (lpm_base[i] & m) &&
                        int'(lpm_len[i]) > best)
                        best = int'(lpm_len[i]);
                end
                if (best >= 0) r.match_len = best[6:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every strobe must match the oldest expected word.
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        if (n_errors < PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, msg);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        t_lpm_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d match %0d",
                                          o_status, o_match_length));
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_status, want.status));
                if (o_match_length !== want.match_len)
                    report_mismatch($sformatf("match_length got %0d want %0d",
                                              o_match_length, want.match_len));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Between words the sender either keeps start high (burst) or drops it
    // for a random gap, so start rises at every point of the busy window.
    task automatic idle_gap();
        int gap;
        gap = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(1, 4);
                2:       gap = $urandom_range(5, 80);
                default: gap = $urandom_range(60, 140);
            endcase
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Called at a falling edge; holds the word until the unit takes it.
    task automatic send_word(input t_stim_row w);
        t_lpm_result predicted;
        i_command       <= w.cmd;
        i_address       <= w.addr;
        i_prefix_length <= w.plen;
        start           <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = lpm_apply(w.cmd, w.addr, w.plen);
        if (w.fixed_exp)
            pending_results.push_back({w.status, w.match_len});
        else
            pending_results.push_back(predicted);
        n_sent++;
        @(negedge i_clk);
        idle_gap();
    endtask

    task automatic issue(input logic [1:0] cmd, input logic [31:0] addr,
                         input logic [5:0] plen);
        send_word({cmd, addr, plen, 1'b0, ST_DONE, MATCH_NONE});
    endtask

    // Sender holds off until every outstanding result is back.
    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Random word shapes
    // ------------------------------------------------------------------

    task automatic rand_prefix(output logic [31:0] addr, output logic [5:0] plen);
        case ($urandom_range(0, 9))
            0:       plen = 6'($urandom_range(0, 4));
            1:       plen = 6'd32;
            2, 3:    plen = 6'($urandom_range(25, 31));
            default: plen = 6'($urandom_range(5, 24));
        endcase
        addr = $urandom;
    endtask

    // Random valid entry of the shadow table, if any.
    task automatic pick_stored(output bit found, output logic [31:0] base,
                               output logic [5:0] plen);
        int first;
        int k;
        found = 1'b0;
        base  = '0;
        plen  = '0;
        first = $urandom_range(0, TABLE_ENTRIES - 1);
        for (int j = 0; j < TABLE_ENTRIES; j++) begin
            k = (first + j) % TABLE_ENTRIES;
            if (!found && lpm_valid[k]) begin
                found = 1'b1;
                base  = lpm_base[k];
                plen  = lpm_len[k];
            end
        end
    endtask

    task automatic add_random();
        logic [31:0] a;
        logic [5:0]  l;
        rand_prefix(a, l);
        issue(CMD_ADD, a, l);
    endtask

    // Stored prefix with random host bits: must normalize to a hit.
    task automatic hit_stored(input logic [1:0] cmd);
        bit          found;
        logic [31:0] b;
        logic [5:0]  l;
        pick_stored(found, b, l);
        if (found)
            issue(cmd, b | ($urandom & ~prefix_mask(l)), l);
        else
            issue(cmd, $urandom, 6'($urandom_range(0, 32)));
    endtask

    task automatic check_any();
        if ($urandom_range(0, 2) != 0)
            hit_stored(CMD_CHECK);
        else
            issue(CMD_CHECK, $urandom, 6'($urandom_range(0, 63)));
    endtask

    // Adds until the table is full, then pokes the full table.
    task automatic fill_table();
        while (lpm_count() < TABLE_ENTRIES && n_sent < WORD_TARGET) begin
            if ($urandom_range(0, 5) == 0)
                hit_stored(CMD_ADD);
            else
                add_random();
        end
        for (int j = 0; j < 8; j++) begin
            case (j % 4)
                0, 1: add_random();
                2:    hit_stored(CMD_ADD);
                default: check_any();
            endcase
        end
    endtask

    task automatic mixed_traffic(input int n_words);
        for (int j = 0; j < n_words && n_sent < WORD_TARGET; j++) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3, 4, 5: check_any();
                6, 7:   add_random();
                8, 9:   hit_stored(CMD_DELETE);
                10:     issue(CMD_DELETE, $urandom, 6'($urandom_range(0, 32)));
                11:     hit_stored(CMD_ADD);
                12:     issue($urandom_range(0, 1) ? CMD_ADD : CMD_DELETE, $urandom,
                              6'($urandom_range(33, 63)));
                13:     issue(CMD_UNUSED, $urandom, 6'($urandom_range(0, 63)));
                default: issue(CMD_CHECK, $urandom, 6'($urandom_range(0, 63)));
            endcase
        end
    endtask

    task automatic drain_table(input int keep);
        while (lpm_count() > keep && n_sent < WORD_TARGET) begin
            case ($urandom_range(0, 7))
                0:       check_any();
                1:       issue(CMD_DELETE, $urandom, 6'($urandom_range(0, 32)));
                default: hit_stored(CMD_DELETE);
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        int round;
        // Directed words: edges of every field, each command and each status but full.
        directed_rows = '{
            // empty table: no match
            '{CMD_CHECK,  32'hFFFF_FFFF, 6'd0,  1'b1, ST_DONE,       MATCH_NONE},
            '{CMD_ADD,    32'hFFFF_FFFF, 6'd63, 1'b1, ST_BAD_LENGTH, MATCH_NONE},
            '{CMD_DELETE, 32'h0000_0000, 6'd33, 1'b1, ST_BAD_LENGTH, MATCH_NONE},
            '{CMD_DELETE, 32'h0A00_0000, 6'd8,  1'b1, ST_ABSENT,     MATCH_NONE},
            '{CMD_UNUSED, 32'hFFFF_FFFF, 6'd63, 1'b1, ST_DONE,       MATCH_NONE},
            // host route, then its duplicate
            '{CMD_ADD,    32'hFFFF_FFFF, 6'd32, 1'b1, ST_DONE,       MATCH_NONE},
            '{CMD_ADD,    32'hFFFF_FFFF, 6'd32, 1'b1, ST_PRESENT,    MATCH_NONE},
            '{CMD_CHECK,  32'hFFFF_FFFF, 6'd0,  1'b1, ST_DONE,       7'sd32},
            '{CMD_CHECK,  32'hFFFF_FFFE, 6'd63, 1'b0, ST_DONE,       MATCH_NONE},
            // default route: base masks to zero
            '{CMD_ADD,    32'h1234_5678, 6'd0,  1'b0, ST_DONE,       MATCH_NONE},
            '{CMD_ADD,    32'h0000_0000, 6'd0,  1'b0, ST_DONE,       MATCH_NONE},
            '{CMD_CHECK,  32'h0000_0000, 6'd0,  1'b0, ST_DONE,       MATCH_NONE},
            // nested /24 inside /16
            '{CMD_ADD,    32'hC0A8_0155, 6'd24, 1'b0, ST_DONE,       MATCH_NONE},
            '{CMD_CHECK,  32'hC0A8_01FF, 6'd0,  1'b0, ST_DONE,       MATCH_NONE},
            '{CMD_ADD,    32'hC0A8_FFFF, 6'd16, 1'b0, ST_DONE,       MATCH_NONE},
            '{CMD_CHECK,  32'hC0A8_FF01, 6'd0,  1'b0, ST_DONE,       MATCH_NONE},
            '{CMD_DELETE, 32'hC0A8_01AA, 6'd24, 1'b0, ST_DONE,       MATCH_NONE},
            '{CMD_CHECK,  32'hC0A8_01FF, 6'd0,  1'b0, ST_DONE,       MATCH_NONE},
            '{CMD_DELETE, 32'hFFFF_FFFF, 6'd0,  1'b0, ST_DONE,       MATCH_NONE},
            '{CMD_CHECK,  32'h0A00_0000, 6'd0,  1'b0, ST_DONE,       MATCH_NONE},
            '{CMD_ADD,    32'h8000_0000, 6'd1,  1'b0, ST_DONE,       MATCH_NONE},
            '{CMD_CHECK,  32'h7FFF_FFFF, 6'd0,  1'b0, ST_DONE,       MATCH_NONE},
            '{CMD_CHECK,  32'h8000_0001, 6'd0,  1'b0, ST_DONE,       MATCH_NONE},
            '{CMD_DELETE, 32'hFFFF_FFFF, 6'd32, 1'b0, ST_DONE,       MATCH_NONE},
            '{CMD_UNUSED, 32'h0000_0000, 6'd0,  1'b0, ST_DONE,       MATCH_NONE}
        };

        // Sync reset; the unit then clears its table with busy held high.
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i]);
        wait_drained();

        // Random rounds: fill to full, mix, drain to empty or a few entries.
        round = 0;
        while (n_sent < WORD_TARGET) begin
            fill_table();
            mixed_traffic(60);
            drain_table((round % 2 == 0) ? 0 : $urandom_range(1, 24));
            wait_drained();
            round++;
        end

        // Quiet tail: catch any stray strobe after the last word.
        repeat (TABLE_ENTRIES + 8) @(posedge i_clk);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
